>>> src/ble_pkg.sv
// Shared types and constants of the bounded list engine.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ble_pkg;

  localparam int CMD_W   = 4;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int NUM_W   = 7;
  localparam int ST_W    = 3;
  localparam int MAX_OUT = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 4'd0,
    CMD_PREPEND = 4'd1,
    CMD_INSERT  = 4'd2,
    CMD_DELETE  = 4'd3,
    CMD_SEARCH  = 4'd4,
    CMD_COUNT   = 4'd5,
    CMD_DEDUP   = 4'd6,
    CMD_SWAP    = 4'd7,
    CMD_ROTATE  = 4'd8,
    CMD_PALIN   = 4'd9,
    CMD_MIDDLE  = 4'd10,
    CMD_DUMP    = 4'd11
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PASS,
    S_PASS2,
    S_SPIN,
    S_COMPACT,
    S_REPLY
  } state_e;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;
    logic collapse;
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/ble_if.sv
// Valid/ready channel interfaces for command requests and result requests.
// Depends on ble_pkg for field widths.
`default_nettype none

interface ble_cmd_if;
  import ble_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] data_in;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, data_in, position, input ready);
  modport sink   (input valid, command, data_in, position, output ready);
endinterface

interface ble_res_if;
  import ble_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] data_out;
  logic [NUM_W-1:0]         number;
  logic                     answer_flag;
  logic                     last;

  modport source (output valid, status, data_out, number, answer_flag, last, input ready);
  modport sink   (input valid, status, data_out, number, answer_flag, last, output ready);
endinterface

`default_nettype wire

>>> src/ble_cell.sv
// One cell of the list chain: an entry word, its hole tag and a stack word.
// Depends on ble_pkg for the cell control struct.
`default_nettype none

module ble_cell (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire ble_pkg::cell_ctl_t         ctl_i,
  input  wire logic signed [ble_pkg::DATA_W-1:0] nxt_data_i,
  input  wire                             nxt_hole_i,
  input  wire                             prv_hole_i,
  input  wire logic signed [ble_pkg::DATA_W-1:0] stk_prv_i,
  input  wire logic signed [ble_pkg::DATA_W-1:0] stk_nxt_i,
  output logic signed [ble_pkg::DATA_W-1:0] data_o,
  output logic                            hole_o,
  output logic signed [ble_pkg::DATA_W-1:0] stk_o
);
  import ble_pkg::*;

  logic signed [DATA_W-1:0] data_q, stk_q;
  logic                     hole_q, hole_d;
  logic                     take;

  // Take from the right on a shift, or when collapsing into a hole.
  assign take = ctl_i.shift || (ctl_i.collapse && hole_q);

  always_comb begin
    hole_d = hole_q;
    if (ctl_i.shift) begin
      hole_d = nxt_hole_i;
    end else if (ctl_i.collapse) begin
      hole_d = hole_q ? nxt_hole_i : prv_hole_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hole_q <= 1'b1;
    end else begin
      hole_q <= hole_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= nxt_data_i;
    end
    if (ctl_i.push) begin
      stk_q <= stk_prv_i;
    end else if (ctl_i.pop) begin
      stk_q <= stk_nxt_i;
    end
  end

  assign data_o = data_q;
  assign hole_o = hole_q;
  assign stk_o  = stk_q;

endmodule

`default_nettype wire

>>> src/bounded_list_engine.sv
// Bounded list engine: a chain of cells holding an ordered list of words.
// Depends on ble_pkg, ble_if (channel interfaces) and ble_cell.
//
// cmd_i takes one command request (command, data_in, position) at a rising
// edge with valid and ready high; ready is high only while idle, so one
// command is worked at a time. res_o gives result requests from an output
// register: one per command, or one per held entry for dump (at most 64),
// the final one marked by last.
// Flow: a rejected command (full, empty, bad position, unknown code) goes
// straight to loading its result. Others walk the ring of DEPTH+1 cells
// once, check the chain and load the result. Palindrome walks twice,
// rotate spins the ring on further, and reshaping commands then close up
// holes before the result is loaded.
// Reset: clear the count, mark every cell a hole, empty the output register;
// entry words are undefined until written.
// Stall: hold the output register; a dump stops the ring until each entry is
// taken. A new command may be taken while the last result still waits.
`default_nettype none

module bounded_list_engine #(
  parameter int DEPTH = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ble_cmd_if.sink      cmd_i,
  ble_res_if.source    res_o
);
  import ble_pkg::*;

  localparam int R  = DEPTH + 1;          // ring length, one spare cell
  localparam int CW = $clog2(R);          // count and walk index width
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Chain
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_data [R];
  logic signed [DATA_W-1:0] cell_stk  [R];
  logic [R-1:0]             hole_vec;
  logic signed [DATA_W-1:0] feed_data;
  logic                     feed_hole;
  logic                     sfx_done;

  // Control and walk state
  state_e                   state_q, state_d;
  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [CW-1:0]            pidx_q, pidx_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            t_q, t_d;
  logic signed [DATA_W-1:0] stash_q, stash_d;
  logic                     pend_q, pend_d;
  logic signed [DATA_W-1:0] prev_q, prev_d;
  logic [CW-1:0]            acc_q, acc_d;
  logic                     found_q, found_d;
  logic [CW-1:0]            fpos_q, fpos_d;
  logic                     pal_q, pal_d;
  logic signed [DATA_W-1:0] rdat_q, rdat_d;
  logic                     early_q, early_d;
  st_e                      est_q, est_d;

  // Output register
  logic                     res_vld_q, res_vld_d;
  logic [ST_W-1:0]          res_st_q, res_st_d;
  logic signed [DATA_W-1:0] res_data_q, res_data_d;
  logic [NUM_W-1:0]         res_num_q, res_num_d;
  logic                     res_flag_q, res_flag_d;
  logic                     res_last_q, res_last_d;
  logic                     res_load;
  logic                     out_free;

  // Walk helpers
  logic                     accept;
  logic signed [DATA_W-1:0] x;
  logic                     in_list;
  logic                     at_p, past_p;
  logic                     dump_emit;
  logic                     adv;
  logic                     walk_end;
  logic                     spin_end;
  logic [XW-1:0]            tx, nx, px, posx;
  cmd_e                     cmd;

  assign cmd       = cmd_e'(cmd_q);
  assign x         = cell_data[0];
  assign tx        = XW'(t_q);
  assign nx        = XW'(cnt_q);
  assign px        = XW'(pidx_q);
  assign posx      = XW'(cmd_i.position);
  assign in_list   = tx < nx;
  assign at_p      = tx == px;
  assign past_p    = tx > px;
  assign out_free  = !res_vld_q || res_o.ready;
  assign dump_emit = (state_q == S_PASS) && (cmd == CMD_DUMP) && in_list &&
                     (tx < XW'(MAX_OUT));
  // Hold the ring while a dumped entry cannot enter the output register.
  assign adv       = !(dump_emit && !out_free);
  assign walk_end  = t_q == CW'(R - 1);
  assign spin_end  = tx + XW'(2) == nx;
  assign accept    = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = state_q == S_IDLE;

  // Holes all sit at the tail end of the chain.
  assign sfx_done = &(~hole_vec[R-2:0] | hole_vec[R-1:1]);

  // ---------------------------------------------------------------- chain
  for (genvar k = 0; k < R; k++) begin : g_cell
    logic signed [DATA_W-1:0] nd, sp, sn;
    logic                     nh, ph;
    if (k == R - 1) begin : g_tail
      assign nd = feed_data;
      assign nh = feed_hole;
      assign sn = '0;
    end else begin : g_body
      assign nd = cell_data[k+1];
      assign nh = hole_vec[k+1];
      assign sn = cell_stk[k+1];
    end
    if (k == 0) begin : g_head
      assign ph = 1'b0;
      assign sp = x;
    end else begin : g_rest
      assign ph = hole_vec[k-1];
      assign sp = cell_stk[k-1];
    end
    ble_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .nxt_data_i (nd),
      .nxt_hole_i (nh),
      .prv_hole_i (ph),
      .stk_prv_i  (sp),
      .stk_nxt_i  (sn),
      .data_o     (cell_data[k]),
      .hole_o     (hole_vec[k]),
      .stk_o      (cell_stk[k])
    );
  end

  // ----------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = early_d ? S_REPLY : S_PASS;
        end
      end
      S_PASS: begin
        if (adv && walk_end) begin
          if (cmd == CMD_PALIN) begin
            state_d = S_PASS2;
          end else if (cmd == CMD_ROTATE && cnt_q > CW'(1)) begin
            state_d = S_SPIN;
          end else begin
            state_d = S_COMPACT;
          end
        end
      end
      S_PASS2: begin
        if (walk_end) begin
          state_d = S_COMPACT;
        end
      end
      S_SPIN: begin
        if (spin_end) begin
          state_d = S_COMPACT;
        end
      end
      S_COMPACT: begin
        if (sfx_done) begin
          state_d = (cmd == CMD_DUMP) ? S_IDLE : S_REPLY;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------- chain control, feed
  always_comb begin
    ctl       = '0;
    feed_data = x;
    feed_hole = hole_vec[0];
    case (state_q)
      S_PASS: begin
        ctl.shift = adv;
        ctl.push  = adv && in_list && (cmd == CMD_PALIN);
        feed_hole = !in_list;
        case (cmd)
          CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
            if (at_p) begin
              feed_data = val_q;
              feed_hole = 1'b0;
            end else if (past_p) begin
              feed_data = stash_q;
              feed_hole = !pend_q;
            end
          end
          CMD_DELETE: begin
            if (at_p) begin
              feed_hole = 1'b1;
            end
          end
          CMD_DEDUP: begin
            if (in_list && t_q != '0 && x == prev_q) begin
              feed_hole = 1'b1;
            end
          end
          CMD_SWAP: begin
            // Even slots give out the held entry, odd slots pass through.
            if (!in_list || !t_q[0]) begin
              feed_data = stash_q;
              feed_hole = !pend_q;
            end
          end
          default: ;
        endcase
      end
      S_PASS2: begin
        ctl.shift = 1'b1;
        ctl.pop   = 1'b1;
      end
      S_SPIN: begin
        ctl.shift = 1'b1;
      end
      S_COMPACT: begin
        ctl.collapse = !sfx_done;
        feed_hole    = 1'b1;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- datapath
  always_comb begin
    cmd_d   = cmd_q;
    val_d   = val_q;
    pidx_d  = pidx_q;
    cnt_d   = cnt_q;
    t_d     = t_q;
    stash_d = stash_q;
    pend_d  = pend_q;
    prev_d  = prev_q;
    acc_d   = acc_q;
    found_d = found_q;
    fpos_d  = fpos_q;
    pal_d   = pal_q;
    rdat_d  = rdat_q;
    early_d = early_q;
    est_d   = est_q;

    res_load   = 1'b0;
    res_st_d   = res_st_q;
    res_data_d = res_data_q;
    res_num_d  = res_num_q;
    res_flag_d = res_flag_q;
    res_last_d = res_last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i.command;
          val_d   = cmd_i.data_in;
          t_d     = '0;
          pend_d  = 1'b0;
          acc_d   = '0;
          found_d = 1'b0;
          pal_d   = 1'b1;
          est_d   = ST_OK;
          early_d = 1'b0;
          pidx_d  = CW'(posx - XW'(1));
          case (cmd_e'(cmd_i.command))
            CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
              if (nx >= XW'(DEPTH)) begin
                early_d = 1'b1;
                est_d   = ST_FULL;
              end else if (cmd_e'(cmd_i.command) == CMD_INSERT &&
                           (posx == '0 || posx > nx + XW'(1))) begin
                early_d = 1'b1;
                est_d   = ST_BAD_POS;
              end
              if (cmd_e'(cmd_i.command) == CMD_APPEND) begin
                pidx_d = cnt_q;
              end else if (cmd_e'(cmd_i.command) == CMD_PREPEND) begin
                pidx_d = '0;
              end
            end
            CMD_DELETE: begin
              if (cnt_q == '0) begin
                early_d = 1'b1;
                est_d   = ST_EMPTY;
              end else if (posx == '0 || posx > nx) begin
                early_d = 1'b1;
                est_d   = ST_BAD_POS;
              end
            end
            CMD_SEARCH, CMD_COUNT, CMD_DEDUP, CMD_SWAP, CMD_ROTATE,
            CMD_PALIN, CMD_MIDDLE, CMD_DUMP: begin
              if (cnt_q == '0) begin
                early_d = 1'b1;
                est_d   = ST_EMPTY;
              end
            end
            default: early_d = 1'b1;
          endcase
        end
      end

      S_PASS: begin
        if (adv) begin
          t_d = t_q + CW'(1);
          case (cmd)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
              if (!(tx < px)) begin
                stash_d = x;
                pend_d  = in_list;
              end
            end
            CMD_DELETE: begin
              if (at_p) begin
                rdat_d = x;
              end
            end
            CMD_SEARCH: begin
              if (in_list && x == val_q && !found_q) begin
                found_d = 1'b1;
                fpos_d  = t_q + CW'(1);
              end
            end
            CMD_COUNT: begin
              if (in_list && x == val_q) begin
                acc_d = acc_q + CW'(1);
              end
            end
            CMD_DEDUP: begin
              if (in_list) begin
                prev_d = x;
                if (t_q == '0 || x != prev_q) begin
                  acc_d = acc_q + CW'(1);
                end
              end
            end
            CMD_SWAP: begin
              if (!in_list || !t_q[0]) begin
                stash_d = x;
                pend_d  = in_list;
              end
            end
            CMD_MIDDLE: begin
              if (in_list && t_q == (cnt_q >> 1)) begin
                rdat_d = x;
              end
            end
            CMD_DUMP: begin
              if (dump_emit) begin
                res_load   = 1'b1;
                res_st_d   = ST_OK;
                res_data_d = x;
                res_num_d  = NUM_W'(cnt_q);
                res_flag_d = 1'b0;
                res_last_d = (tx + XW'(1) == nx) || (tx == XW'(MAX_OUT - 1));
              end
            end
            default: ;
          endcase
          if (walk_end) begin
            t_d = '0;
            case (cmd)
              CMD_APPEND, CMD_PREPEND, CMD_INSERT: cnt_d = cnt_q + CW'(1);
              CMD_DELETE:                          cnt_d = cnt_q - CW'(1);
              CMD_DEDUP:                           cnt_d = acc_q;
              default: ;
            endcase
          end
        end
      end

      S_PASS2: begin
        t_d = t_q + CW'(1);
        // Compare the front half against the reversed copy on the stack.
        if (t_q < (cnt_q >> 1) && x != cell_stk[0]) begin
          pal_d = 1'b0;
        end
      end

      S_SPIN: begin
        t_d = t_q + CW'(1);
      end

      S_REPLY: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_st_d   = ST_OK;
          res_data_d = '0;
          res_num_d  = NUM_W'(cnt_q);
          res_flag_d = 1'b0;
          res_last_d = 1'b1;
          if (early_q) begin
            res_st_d   = est_q;
            res_flag_d = (est_q == ST_EMPTY) && (cmd == CMD_PALIN);
          end else begin
            case (cmd)
              CMD_DELETE, CMD_MIDDLE: res_data_d = rdat_q;
              CMD_SEARCH: begin
                res_st_d  = found_q ? ST_OK : ST_NOT_FOUND;
                res_num_d = found_q ? NUM_W'(fpos_q) : '0;
              end
              CMD_COUNT: begin
                res_st_d  = (acc_q == '0) ? ST_NOT_FOUND : ST_OK;
                res_num_d = NUM_W'(acc_q);
              end
              CMD_PALIN: res_flag_d = pal_q;
              default: ;
            endcase
          end
        end
      end

      default: ;
    endcase

    res_vld_d = res_load ? 1'b1 : (res_o.ready ? 1'b0 : res_vld_q);
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
      t_q       <= '0;
      early_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_vld_q <= res_vld_d;
      t_q       <= t_d;
      early_q   <= early_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    val_q      <= val_d;
    pidx_q     <= pidx_d;
    stash_q    <= stash_d;
    pend_q     <= pend_d;
    prev_q     <= prev_d;
    acc_q      <= acc_d;
    found_q    <= found_d;
    fpos_q     <= fpos_d;
    pal_q      <= pal_d;
    rdat_q     <= rdat_d;
    est_q      <= est_d;
    res_st_q   <= res_st_d;
    res_data_q <= res_data_d;
    res_num_q  <= res_num_d;
    res_flag_q <= res_flag_d;
    res_last_q <= res_last_d;
  end

  assign res_o.valid       = res_vld_q;
  assign res_o.status      = res_st_q;
  assign res_o.data_out    = res_data_q;
  assign res_o.number      = res_num_q;
  assign res_o.answer_flag = res_flag_q;
  assign res_o.last        = res_last_q;

`ifndef SYNTHESIS
  // Between commands the chain is closed up: held entries, then holes.
  a_idle_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> sfx_done)
    else $error("holes left inside the list while idle");

  // The number of non-hole cells matches the entry count when idle.
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(~hole_vec) == int'(cnt_q))
    else $error("cell occupancy disagrees with entry count");

  // Never load the output register over a result not yet taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_vld_q) |-> res_o.ready)
    else $error("result register overwritten while stalled");

  // The count never runs past the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= DEPTH)
    else $error("entry count beyond capacity");
`endif

endmodule

`default_nettype wire
